[src/ws_pkg.sv]
// ----------------------------------------------------------------------------
// WS2812 driver package
// Shared constants, codes and types of the WS2812 LED chain driver.
// ----------------------------------------------------------------------------
package ws_pkg;

  // Pixel store size and derived widths.
  localparam int MAX_LEDS     = 256;
  localparam int PIX_AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int POS_W        = 9;
  localparam int RD_W         = (POS_W + 1 > PIX_AW) ? POS_W + 1 : PIX_AW;
  localparam int PIX_W        = 24;
  localparam int CHAN_W       = 8;
  localparam int TICK_W       = 16;
  localparam int RSLOT_W      = 8;
  localparam int BIT_W        = 5;
  localparam int BITS_PER_LED = 24;
  localparam int MSB_BIT      = 23;
  localparam int ACT_W        = 3;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Command codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_FILL  = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_START = 3'd3,
    ACT_TICK  = 3'd4
  } action_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_COUNT   = 3'd0,
    REG_BIT_PERIOD  = 3'd1,
    REG_ONE_HIGH    = 3'd2,
    REG_ZERO_HIGH   = 3'd3,
    REG_RESET_SLOTS = 3'd4
  } reg_idx_t;

  // Command sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_LOAD,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [POS_W-1:0]   led_count;
    logic [TICK_W-1:0]  bit_period;
    logic [TICK_W-1:0]  one_high;
    logic [TICK_W-1:0]  zero_high;
    logic [RSLOT_W-1:0] reset_slots;
  } cfg_regs_t;

  // Requests from the command sequencer to the frame sequencer.
  typedef struct packed {
    logic start;
    logic tick;
    logic load;
  } frame_ctrl_t;

  // Frame sequencer status; done is valid in the cycle of a tick.
  typedef struct packed {
    logic level;
    logic sending;
    logic done;
  } frame_stat_t;

  typedef struct packed {
    logic              en;
    logic [PIX_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } pix_wr_t;

  typedef struct packed {
    logic            en;
    logic [RD_W-1:0] pos;
  } pix_rd_t;

  typedef struct packed {
    logic              line_level;
    logic              busy_res;
    logic [STAT_W-1:0] status;
    logic              frame_done;
  } res_word_t;

  // Number of LEDs actually sent, limited by the store size.
  function automatic logic [POS_W-1:0] chain_len(input logic [POS_W-1:0] cnt);
    logic [POS_W-1:0] n;
    if (cnt > MAX_LEDS) begin
      n = POS_W'(MAX_LEDS);
    end else begin
      n = cnt;
    end
    return n;
  endfunction

endpackage

[src/ws_chan_if.sv]
// ----------------------------------------------------------------------------
// WS2812 driver channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------

// Command channel: one command per transfer.
interface ws_cmd_if import ws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAN_W-1:0] led_index;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, action, led_index, red, green, blue, input ready);
  modport sink   (input valid, action, led_index, red, green, blue, output ready);
endinterface

// Result channel: one result per command.
interface ws_res_if import ws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              line_level;
  logic              busy_res;
  logic [STAT_W-1:0] status;
  logic              frame_done;

  modport source (output valid, line_level, busy_res, status, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, status, frame_done, output ready);
endinterface

// Configuration write channel.
interface ws_cfg_if import ws_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ws_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ws_pix_store.sv]
// ----------------------------------------------------------------------------
// WS2812 pixel store
// Color memory with per-entry valid bits, so that the store reads as black
// right after reset. Positions past the end of the store read as black too.
// ----------------------------------------------------------------------------
module ws_pix_store import ws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  pix_wr_t          wr,
  input  pix_rd_t          rd,
  output logic [PIX_W-1:0] rd_data
);

  logic [MAX_LEDS-1:0] valid;
  logic [PIX_AW-1:0]   rd_addr;
  logic                rd_hit;
  logic                rd_ok;
  logic [PIX_W-1:0]    ram_q;

  assign rd_addr = rd.pos[PIX_AW-1:0];
  assign rd_hit  = (rd.pos < MAX_LEDS);

  ws_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LEDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Valid bits: cleared at reset, set by any write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Track whether the pending read returns real data.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_ok <= rd_hit && valid[rd_addr];
    end
  end

  assign rd_data = rd_ok ? ram_q : '0;

endmodule

[src/ws_frame_seq.sv]
// ----------------------------------------------------------------------------
// WS2812 frame sequencer
// Tracks the position in the frame, times each bit slot and derives the line
// level. The next pixel is fetched from the store well ahead of its use.
// ----------------------------------------------------------------------------
module ws_frame_seq import ws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_regs_t        regs,
  input  frame_ctrl_t      ctrl,
  input  logic [PIX_W-1:0] rd_data,
  output pix_rd_t          rd_req,
  output frame_stat_t      stat
);

  logic               sending,        sending_next;
  logic [POS_W-1:0]   led_position,   led_position_next;
  logic [BIT_W-1:0]   bit_position,   bit_position_next;
  logic [TICK_W-1:0]  slot_tick,      slot_tick_next;
  logic [RSLOT_W-1:0] reset_position, reset_position_next;
  logic [PIX_W-1:0]   shift_word,     shift_word_next;
  logic [PIX_W-1:0]   next_pix,       next_pix_next;
  logic               pend,           pend_next;

  logic [POS_W-1:0]   n;
  logic               in_chain;
  logic [TICK_W-1:0]  high;
  logic [TICK_W-1:0]  st_inc;
  logic               slot_end;
  logic [BIT_W-1:0]   bp_inc;
  logic [RSLOT_W-1:0] rp_inc;
  logic [POS_W-1:0]   lp_inc;
  logic               done;

  // Slot timing and the current line level.
  always_comb begin
    n        = chain_len(regs.led_count);
    in_chain = (led_position < n);
    high     = shift_word[MSB_BIT] ? regs.one_high : regs.zero_high;
    st_inc   = slot_tick + TICK_W'(1);
    slot_end = (st_inc >= regs.bit_period) || (st_inc == '0);
    bp_inc   = bit_position + BIT_W'(1);
    rp_inc   = reset_position + RSLOT_W'(1);
    lp_inc   = led_position + POS_W'(1);
  end

  assign stat.level   = sending && in_chain && (slot_tick < high);
  assign stat.sending = sending;
  assign stat.done    = done;

  // Frame state update for start, first pixel load and ticks.
  always_comb begin
    sending_next        = sending;
    led_position_next   = led_position;
    bit_position_next   = bit_position;
    slot_tick_next      = slot_tick;
    reset_position_next = reset_position;
    shift_word_next     = shift_word;
    next_pix_next       = pend ? rd_data : next_pix;
    pend_next           = 1'b0;
    rd_req              = '0;
    done                = 1'b0;

    priority if (ctrl.start) begin
      // Clear the position and fetch the first pixel.
      sending_next        = 1'b1;
      led_position_next   = '0;
      bit_position_next   = '0;
      slot_tick_next      = '0;
      reset_position_next = '0;
      shift_word_next     = '0;
      rd_req.en           = 1'b1;
      rd_req.pos          = '0;
    end else if (ctrl.load) begin
      // First pixel arrives; prefetch the second one.
      shift_word_next = rd_data;
      rd_req.en       = 1'b1;
      rd_req.pos      = RD_W'(1);
      pend_next       = 1'b1;
    end else if (ctrl.tick && sending) begin
      if (in_chain) begin
        slot_tick_next = slot_end ? '0 : st_inc;
        if (slot_end) begin
          shift_word_next   = {shift_word[PIX_W-2:0], 1'b0};
          bit_position_next = bp_inc;
          if (bp_inc >= BITS_PER_LED) begin
            // Move to the next LED and prefetch the one after it.
            bit_position_next = '0;
            led_position_next = lp_inc;
            shift_word_next   = next_pix;
            rd_req.en         = 1'b1;
            rd_req.pos        = RD_W'(lp_inc) + RD_W'(1);
            pend_next         = 1'b1;
            if ((lp_inc >= n) && (regs.reset_slots == '0)) begin
              done = 1'b1;
            end
          end
        end
      end else if (reset_position >= regs.reset_slots) begin
        done = 1'b1;
      end else begin
        // Latch code: count low slots.
        slot_tick_next = slot_end ? '0 : st_inc;
        if (slot_end) begin
          reset_position_next = rp_inc;
          if (rp_inc >= regs.reset_slots) begin
            done = 1'b1;
          end
        end
      end

      if (done) begin
        sending_next        = 1'b0;
        led_position_next   = '0;
        bit_position_next   = '0;
        slot_tick_next      = '0;
        reset_position_next = '0;
        shift_word_next     = '0;
      end
    end else begin
      // No frame activity this cycle.
      pend_next = 1'b0;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sending        <= 1'b0;
      led_position   <= '0;
      bit_position   <= '0;
      slot_tick      <= '0;
      reset_position <= '0;
      shift_word     <= '0;
      next_pix       <= '0;
      pend           <= 1'b0;
    end else begin
      sending        <= sending_next;
      led_position   <= led_position_next;
      bit_position   <= bit_position_next;
      slot_tick      <= slot_tick_next;
      reset_position <= reset_position_next;
      shift_word     <= shift_word_next;
      next_pix       <= next_pix_next;
      pend           <= pend_next;
    end
  end

endmodule

[src/ws2812_led_chain_driver.sv]
// ----------------------------------------------------------------------------
// WS2812 LED chain driver
// Commands on cmd write pixels, fill or clear the store, start a frame or
// advance the line timer by one tick. Each command gives one result on res,
// carrying the line level, the busy flag, a status code and the end of frame.
// Configuration registers are written on cfg, which is always ready.
// Write pixel, tick, rejected and unused commands give their result straight
// from the idle state, so a tick can be given every cycle while results are
// taken. Start passes through a load state, as the first pixel is read from
// the store memory, whose read port has registered data. Fill and clear sweep
// the lit length, led_count capped at the store size, writing one pixel per
// cycle through the single write port, then give their result.
// Results come from an output register; a new command is taken while the
// previous result waits only if that result is taken in the same cycle.
// When res stalls, cmd.ready drops and the result is held unchanged.
// Reset clears the frame state, restores the register defaults and marks
// every pixel as black at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module ws2812_led_chain_driver import ws_pkg::*; (
  input logic     clk,
  input logic     rst,
  ws_cmd_if.sink  cmd,
  ws_res_if.source res,
  ws_cfg_if.sink  cfg
);

  cfg_regs_t        regs;
  seq_state_t       state, state_next;
  logic [POS_W-1:0] fill_pos, fill_pos_next;
  logic [PIX_W-1:0] fill_color, fill_color_next;
  logic             res_valid, res_valid_next;
  res_word_t        res_word, res_word_next;
  logic             emit;
  logic             out_free;
  logic [POS_W-1:0] n;
  logic [PIX_W-1:0] color;

  frame_ctrl_t      fctrl;
  frame_stat_t      fstat;
  pix_wr_t          wr;
  pix_rd_t          rd_req;
  logic [PIX_W-1:0] rd_data;

  ws_pix_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  ws_frame_seq u_frame (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .ctrl    (fctrl),
    .rd_data (rd_data),
    .rd_req  (rd_req),
    .stat    (fstat)
  );

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.led_count   <= '0;
      regs.bit_period  <= TICK_W'(105);
      regs.one_high    <= TICK_W'(70);
      regs.zero_high   <= TICK_W'(35);
      regs.reset_slots <= RSLOT_W'(50);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LED_COUNT:   regs.led_count   <= cfg.data[POS_W-1:0];
        REG_BIT_PERIOD:  regs.bit_period  <= cfg.data;
        REG_ONE_HIGH:    regs.one_high    <= cfg.data;
        REG_ZERO_HIGH:   regs.zero_high   <= cfg.data;
        REG_RESET_SLOTS: regs.reset_slots <= cfg.data[RSLOT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n        = chain_len(regs.led_count);
  assign color    = {cmd.green, cmd.red, cmd.blue};
  assign out_free = !res_valid || res.ready;

  // Command sequencer: next state, store writes and result.
  always_comb begin
    state_next      = state;
    cmd.ready       = 1'b0;
    fctrl           = '0;
    wr              = '0;
    fill_pos_next   = fill_pos;
    fill_color_next = fill_color;
    emit            = 1'b0;
    res_word_next   = '{line_level: fstat.level, busy_res: fstat.sending,
                        status: ST_OK, frame_done: 1'b0};

    unique case (state)
      S_IDLE: begin
        cmd.ready = out_free;
        if (cmd.valid && out_free) begin
          priority if ((cmd.action <= ACT_START) && fstat.sending) begin
            emit                 = 1'b1;
            res_word_next.status = ST_BUSY;
          end else begin
            unique case (cmd.action)
              ACT_WRITE: begin
                emit = 1'b1;
                if (({1'b0, cmd.led_index} >= n) || (cmd.led_index >= MAX_LEDS)) begin
                  res_word_next.status = ST_RANGE;
                end else begin
                  wr.en   = 1'b1;
                  wr.addr = PIX_AW'(cmd.led_index);
                  wr.data = color;
                end
              end
              ACT_FILL, ACT_CLEAR: begin
                fill_pos_next   = '0;
                fill_color_next = (cmd.action == ACT_FILL) ? color : '0;
                state_next      = S_FILL;
              end
              ACT_START: begin
                fctrl.start = 1'b1;
                state_next  = S_LOAD;
              end
              ACT_TICK: begin
                fctrl.tick                 = 1'b1;
                emit                       = 1'b1;
                res_word_next.busy_res     = fstat.sending && !fstat.done;
                res_word_next.frame_done   = fstat.done;
              end
              default: begin
                emit = 1'b1;
              end
            endcase
          end
        end
      end

      S_FILL: begin
        // Sweep the lit part of the store, one pixel per cycle.
        if (fill_pos < n) begin
          wr.en         = 1'b1;
          wr.addr       = PIX_AW'(fill_pos);
          wr.data       = fill_color;
          fill_pos_next = fill_pos + POS_W'(1);
        end else begin
          state_next = S_DONE;
        end
      end

      S_LOAD: begin
        fctrl.load = 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      res_valid_next = 1'b1;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      fill_pos  <= '0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      fill_pos  <= fill_pos_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fill_color <= fill_color_next;
    if (emit) begin
      res_word <= res_word_next;
    end
  end

  assign res.valid      = res_valid;
  assign res.line_level = res_word.line_level;
  assign res.busy_res   = res_word.busy_res;
  assign res.status     = res_word.status;
  assign res.frame_done = res_word.frame_done;

endmodule

[bench/ws2812_led_chain_driver_checker.sv]
// ----------------------------------------------------------------------------
// WS2812 LED chain driver checker
// Watches the command, result and configuration channels of the driver. It
// keeps its own copy of the pixel store, the frame state and the registers,
// works out the result of every command transfer, and compares each result
// transfer field by field with the oldest result still due.
// ----------------------------------------------------------------------------
module ws2812_led_chain_driver_checker import ws_pkg::*; (
  input  logic clk,
  input  logic rst,
  ws_cmd_if    cmd,
  ws_res_if    res,
  ws_cfg_if    cfg,
  output int   fails,
  output int   pending,
  output int   compared,
  output int   frames
);

  // Predicted state of the driver.
  cfg_regs_t          regs;
  logic [PIX_W-1:0]   pix_mem [MAX_LEDS];
  logic               on_air;
  logic [POS_W-1:0]   led_pos;
  logic [BIT_W-1:0]   bit_cnt;
  logic [TICK_W-1:0]  slot_cnt;
  logic [RSLOT_W-1:0] latch_cnt;
  logic [PIX_W-1:0]   out_word;

  // Results worked out for accepted commands, oldest first.
  res_word_t results_due[$];
  res_word_t want;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [STAT_W-1:0] seen,
                             input logic [STAT_W-1:0] due);
    if (seen !== due) begin
      report($sformatf("result %0d: %s is %0d, expected %0d", compared, name, seen, due));
    end
  endtask

  // Number of LEDs a frame sends; the store size caps the register.
  function automatic logic [POS_W-1:0] leds_sent();
    if (regs.led_count > MAX_LEDS) begin
      return POS_W'(MAX_LEDS);
    end
    return regs.led_count;
  endfunction

  // Pixels beyond the store read as black.
  function automatic logic [PIX_W-1:0] pixel_at(input logic [POS_W-1:0] p);
    if (p < MAX_LEDS) begin
      return pix_mem[p[PIX_AW-1:0]];
    end
    return '0;
  endfunction

  // Line level for the present slot position; low outside the data part.
  function automatic logic line_now();
    logic [TICK_W-1:0] hi;
    if (!on_air || led_pos >= leds_sent()) begin
      return 1'b0;
    end
    hi = out_word[MSB_BIT] ? regs.one_high : regs.zero_high;
    return slot_cnt < hi;
  endfunction

  // Counts one tick of the slot; true when the slot has ended.
  function automatic bit slot_ends();
    slot_cnt = slot_cnt + 1'b1;
    if (slot_cnt >= regs.bit_period || slot_cnt == '0) begin
      slot_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One tick of a running frame; true when the frame has ended.
  function automatic bit frame_step();
    logic [POS_W-1:0] n;
    n = leds_sent();
    if (led_pos < n) begin
      if (slot_ends()) begin
        out_word = out_word << 1;
        bit_cnt++;
        if (bit_cnt >= BITS_PER_LED) begin
          bit_cnt  = '0;
          led_pos++;
          out_word = pixel_at(led_pos);
          if (led_pos >= n && regs.reset_slots == '0) begin
            return 1'b1;
          end
        end
      end
      return 1'b0;
    end
    // Latch part: low slots after the data.
    if (latch_cnt >= regs.reset_slots) begin
      return 1'b1;
    end
    if (slot_ends()) begin
      latch_cnt++;
      if (latch_cnt >= regs.reset_slots) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic park_frame();
    on_air    = 1'b0;
    led_pos   = '0;
    bit_cnt   = '0;
    slot_cnt  = '0;
    latch_cnt = '0;
    out_word  = '0;
  endtask

  // Applies one command to the predicted state and returns its result.
  task automatic run_led_command(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] idx,
                                 input logic [PIX_W-1:0] color, output res_word_t r);
    logic [POS_W-1:0]  n;
    logic              lvl;
    logic [STAT_W-1:0] st;
    logic              done;
    n    = leds_sent();
    lvl  = line_now();
    st   = ST_OK;
    done = 1'b0;
    if (act <= ACT_START && on_air) begin
      st = ST_BUSY;
    end else begin
      case (act)
        ACT_WRITE: begin
          if (idx >= n) begin
            st = ST_RANGE;
          end else begin
            pix_mem[idx] = color;
          end
        end
        ACT_FILL: begin
          for (int i = 0; i < n; i++) pix_mem[i] = color;
        end
        ACT_CLEAR: begin
          for (int i = 0; i < n; i++) pix_mem[i] = '0;
        end
        ACT_START: begin
          park_frame();
          on_air   = 1'b1;
          out_word = pixel_at('0);
          lvl      = line_now();
        end
        ACT_TICK: begin
          if (on_air && frame_step()) begin
            park_frame();
            done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    r.line_level = lvl;
    r.busy_res   = on_air;
    r.status     = st;
    r.frame_done = done;
  endtask

  task automatic restore_defaults();
    regs.led_count   = '0;
    regs.bit_period  = 16'd105;
    regs.one_high    = 16'd70;
    regs.zero_high   = 16'd35;
    regs.reset_slots = 8'd50;
    for (int i = 0; i < MAX_LEDS; i++) pix_mem[i] = '0;
    park_frame();
    results_due.delete();
  endtask

  // Register writes, then result transfers, then command transfers.
  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LED_COUNT:   regs.led_count   = cfg.data[POS_W-1:0];
          REG_BIT_PERIOD:  regs.bit_period  = cfg.data;
          REG_ONE_HIGH:    regs.one_high    = cfg.data;
          REG_ZERO_HIGH:   regs.zero_high   = cfg.data;
          REG_RESET_SLOTS: regs.reset_slots = cfg.data[RSLOT_W-1:0];
          default: begin
          end
        endcase
      end
      if (res.valid && res.ready) begin
        if (results_due.size() == 0) begin
          report($sformatf("result with no command waiting: level %0b busy %0b status %0d done %0b",
                           res.line_level, res.busy_res, res.status, res.frame_done));
        end else begin
          want = results_due.pop_front();
          check_field("line_level", STAT_W'(res.line_level), STAT_W'(want.line_level));
          check_field("busy_res", STAT_W'(res.busy_res), STAT_W'(want.busy_res));
          check_field("status", res.status, want.status);
          check_field("frame_done", STAT_W'(res.frame_done), STAT_W'(want.frame_done));
          compared++;
          if (want.frame_done) begin
            frames++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        run_led_command(cmd.action, cmd.led_index, {cmd.green, cmd.red, cmd.blue}, want);
        results_due.push_back(want);
      end
    end
    pending <= results_due.size();
  end

endmodule

[bench/ws2812_led_chain_driver_tb.sv]
// ----------------------------------------------------------------------------
// WS2812 LED chain driver testbench
// Drives commands and register writes into the driver and takes its results
// with random gaps and stalls. A directed part covers register defaults, the
// timing extremes, range and busy rejections, empty chains and live register
// changes; a random part then runs many short frames under changing settings.
// The checker beside the driver predicts and compares every result.
// ----------------------------------------------------------------------------
module ws2812_led_chain_driver_tb;
  import ws_pkg::*;

  localparam int LIMIT       = 400_000;
  localparam int TOTAL_ITEMS = 1750;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int cycles;
  int fail_cnt, wait_cnt, res_cnt, frame_cnt;
  int gap_pct, stall_pct;
  int hold_asks, hold_done;
  int items, phases;

  // Register values as last written, used to size tick runs.
  logic [POS_W-1:0]   sh_lc;
  logic [TICK_W-1:0]  sh_bp;
  logic [RSLOT_W-1:0] sh_rs;

  ws_cmd_if cmd_ch ();
  ws_res_if res_ch ();
  ws_cfg_if cfg_ch ();

  ws2812_led_chain_driver dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  ws2812_led_chain_driver_checker chk (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg      (cfg_ch),
    .fails    (fail_cnt),
    .pending  (wait_cnt),
    .compared (res_cnt),
    .frames   (frame_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, wait_cnt);
      $display("ws2812_led_chain_driver test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 45; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 45; end
      default: begin gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // One command transfer, after a random gap.
  task automatic send(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] idx,
                      input logic [PIX_W-1:0] rgb);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= act;
    cmd_ch.led_index <= idx;
    cmd_ch.red       <= rgb[23:16];
    cmd_ch.green     <= rgb[15:8];
    cmd_ch.blue      <= rgb[7:0];
    do @(posedge clk); while (!cmd_ch.ready);
    items++;
  endtask

  task automatic tick_n(input int n);
    repeat (n) send(ACT_TICK, CHAN_W'($urandom), PIX_W'($urandom));
  endtask

  // One register write transfer.
  task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_LED_COUNT:   sh_lc = val[POS_W-1:0];
      REG_BIT_PERIOD:  sh_bp = val;
      REG_RESET_SLOTS: sh_rs = val[RSLOT_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Waits until every result has come back and the driver is quiet.
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (wait_cnt != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Ticks that a whole frame takes under the present settings.
  function automatic int frame_ticks();
    int n, p;
    n = (sh_lc > MAX_LEDS) ? MAX_LEDS : sh_lc;
    p = (sh_bp < 2) ? 1 : sh_bp;
    if (n == 0 && sh_rs == 0) begin
      return 1;
    end
    return n * BITS_PER_LED * p + sh_rs * p;
  endfunction

  // Small random settings so that frames stay short.
  task automatic randomize_regs();
    int pick;
    pick = $urandom_range(0, 99);
    set_reg(REG_LED_COUNT, CFG_DATA_W'((pick < 15) ? 0 : (pick < 75) ?
                                       $urandom_range(1, 3) : $urandom_range(4, 10)));
    pick = $urandom_range(0, 99);
    set_reg(REG_BIT_PERIOD, CFG_DATA_W'((pick < 70) ? $urandom_range(2, 3) : (pick < 85) ?
                                        $urandom_range(0, 1) : $urandom_range(4, 6)));
    set_reg(REG_ONE_HIGH, CFG_DATA_W'($urandom_range(0, sh_bp + 2)));
    set_reg(REG_ZERO_HIGH, CFG_DATA_W'($urandom_range(0, sh_bp + 2)));
    set_reg(REG_RESET_SLOTS, CFG_DATA_W'($urandom_range(0, 4)));
  endtask

  // Pixel commands with indexes mostly near the chain length.
  task automatic pixel_burst();
    int pick;
    logic [CHAN_W-1:0] idx;
    repeat ($urandom_range(2, 8)) begin
      pick = $urandom_range(0, 99);
      idx  = CHAN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, sh_lc + 1));
      if (pick < 50) begin
        send(ACT_WRITE, idx, PIX_W'($urandom));
      end else if (pick < 62) begin
        send(ACT_FILL, idx, PIX_W'($urandom));
      end else if (pick < 72) begin
        send(ACT_CLEAR, idx, PIX_W'($urandom));
      end else if (pick < 80) begin
        send(ACT_W'($urandom_range(ACT_TICK + 1, 2**ACT_W - 1)), idx, PIX_W'($urandom));
      end else begin
        send(ACT_TICK, idx, PIX_W'($urandom));
      end
    end
  endtask

  // A frame run to about its end, with rejected commands mixed in.
  task automatic run_frame(input bit squeeze);
    int len;
    send(ACT_START, CHAN_W'($urandom), PIX_W'($urandom));
    len = frame_ticks();
    if ($urandom_range(0, 99) < 15 && len > 3) begin
      len -= $urandom_range(1, 3);
    end else begin
      len += $urandom_range(0, 3);
    end
    if (squeeze) begin
      hold_asks++;
      if (len < 40) len = 40;
    end
    repeat (len) begin
      if ($urandom_range(0, 99) < 4) begin
        send(ACT_W'($urandom_range(ACT_WRITE, ACT_START)), CHAN_W'($urandom),
             PIX_W'($urandom));
      end
      send(ACT_TICK, CHAN_W'($urandom), PIX_W'($urandom));
    end
  endtask

  initial begin
    int spins;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_TICK;
    cmd_ch.led_index = '0;
    cmd_ch.red       = '0;
    cmd_ch.green     = '0;
    cmd_ch.blue      = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_LED_COUNT;
    cfg_ch.data      = '0;
    sh_lc            = '0;
    sh_bp            = 16'd105;
    sh_rs            = 8'd50;
    set_mode(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: empty chain, so every write is out of range and the
    // frame is latch slots only. One slot runs at the default period, the
    // rest of the latch at a short one.
    send(ACT_TICK, 8'h00, 24'h000000);
    send(ACT_WRITE, 8'h00, 24'hffffff);
    for (int a = ACT_TICK + 1; a < 2**ACT_W; a++) send(ACT_W'(a), 8'hff, 24'hffffff);
    send(ACT_FILL, 8'h00, 24'hffffff);
    send(ACT_CLEAR, 8'h00, 24'h000000);
    send(ACT_START, 8'h00, 24'h000000);
    tick_n(int'(sh_bp) + 2);
    settle();
    set_reg(REG_BIT_PERIOD, 2);
    tick_n(frame_ticks() + 1);

    // Three LEDs without latch slots; commands while busy are rejected.
    settle();
    set_reg(REG_LED_COUNT, 3);
    set_reg(REG_BIT_PERIOD, 3);
    set_reg(REG_ONE_HIGH, 2);
    set_reg(REG_ZERO_HIGH, 1);
    set_reg(REG_RESET_SLOTS, 0);
    send(ACT_WRITE, 8'd0, 24'hffffff);
    send(ACT_WRITE, 8'd1, 24'h0ff0a5);
    send(ACT_WRITE, 8'd2, 24'h800001);
    send(ACT_WRITE, 8'd3, 24'h123456);
    send(ACT_WRITE, 8'd255, 24'hfedcba);
    send(ACT_START, 8'd0, 24'h0);
    send(ACT_START, 8'd0, 24'h0);
    send(ACT_WRITE, 8'd1, 24'hffffff);
    send(ACT_FILL, 8'd0, 24'hffffff);
    send(ACT_CLEAR, 8'd0, 24'h0);
    tick_n(frame_ticks() + 2);

    // No data and no latch slots: the frame ends on the first tick.
    settle();
    set_reg(REG_LED_COUNT, 0);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(2);

    // Periods of one and zero ticks both give one-tick slots.
    settle();
    set_reg(REG_LED_COUNT, 1);
    set_reg(REG_RESET_SLOTS, 2);
    set_reg(REG_BIT_PERIOD, 1);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(frame_ticks() + 1);
    settle();
    set_reg(REG_BIT_PERIOD, 0);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(frame_ticks() + 1);

    // High times beyond the period and of zero.
    settle();
    set_reg(REG_BIT_PERIOD, 2);
    set_reg(REG_ONE_HIGH, 16'hffff);
    set_reg(REG_ZERO_HIGH, 0);
    set_reg(REG_LED_COUNT, 2);
    send(ACT_FILL, 8'd0, 24'ha55ac3);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(frame_ticks() + 1);
    settle();
    set_reg(REG_ONE_HIGH, 1);
    set_reg(REG_ZERO_HIGH, 16'hffff);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(frame_ticks() + 1);

    // Oversized count reaches the whole store; dropping the count below the
    // position then starts the longest latch, in one-tick slots.
    settle();
    set_reg(REG_LED_COUNT, 511);
    set_reg(REG_RESET_SLOTS, 255);
    set_reg(REG_ZERO_HIGH, 1);
    send(ACT_FILL, 8'd0, 24'h5a5a5a);
    send(ACT_WRITE, 8'd255, 24'hc3e1f0);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(60);
    settle();
    set_reg(REG_LED_COUNT, 1);
    set_reg(REG_BIT_PERIOD, 1);
    tick_n(int'(sh_rs) + 2);

    // Clearing the full chain leaves black, not stale color.
    settle();
    set_reg(REG_LED_COUNT, 256);
    send(ACT_FILL, 8'd0, 24'hffffff);
    send(ACT_CLEAR, 8'd0, 24'hffffff);
    settle();
    set_reg(REG_LED_COUNT, 1);
    set_reg(REG_RESET_SLOTS, 1);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(frame_ticks() + 1);

    // Registers changed while a frame is on the line take effect at once;
    // dropping the count moves the frame into its latch slots.
    settle();
    set_reg(REG_LED_COUNT, 4);
    set_reg(REG_BIT_PERIOD, 16'hffff);
    set_reg(REG_RESET_SLOTS, 3);
    send(ACT_START, 8'd0, 24'h0);
    tick_n(40);
    settle();
    set_reg(REG_BIT_PERIOD, 2);
    tick_n(60);
    settle();
    set_reg(REG_LED_COUNT, 0);
    tick_n(frame_ticks() + 2);

    // Random phases under every idle mix.
    phases = 0;
    while (items < TOTAL_ITEMS || phases < 4) begin
      settle();
      set_mode(phases % 4);
      randomize_regs();
      pixel_burst();
      run_frame(phases == 0);
      phases++;
    end

    // Drain.
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    spins = 0;
    while (wait_cnt != 0 && spins < 100_000) begin
      @(negedge clk);
      spins++;
    end
    repeat (20) @(negedge clk);

    $display("Sent %0d commands in all, the last of them over %0d random phases.",
             items, phases);
    $display("Compared %0d results; %0d frames ran to their end.", res_cnt, frame_cnt);
    if (fail_cnt == 0 && wait_cnt == 0) begin
      $display("ws2812_led_chain_driver test passed");
    end else begin
      if (wait_cnt != 0) begin
        $display("%0d expected results never arrived", wait_cnt);
      end
      $display("ws2812_led_chain_driver test failed");
    end
    $finish;
  end

endmodule
